// ===== design/rtprb_pkg.sv =====
// ----------------------------------------------------------------------------
// rtprb_pkg
// Types and fixed constants shared by the rtp reorder buffer modules.
// ----------------------------------------------------------------------------
package rtprb_pkg;

    localparam int unsigned SEQ_W         = 16;
    localparam int unsigned LEN_W         = 12;
    localparam int unsigned LOST_W        = 32;
    localparam int unsigned DEPTH_W       = 7;
    localparam int unsigned SLOT_PORT_W   = 6;
    localparam int unsigned EXTW_W        = 16;
    localparam int unsigned BYTE_W        = 8;

    localparam int unsigned MIN_DGRAM_LEN = 12;
    localparam int unsigned EXT_HDR_BYTES = 4;
    localparam logic [1:0]  RTP_VERSION   = 2'd2;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 7'd8;

    typedef struct packed {
        logic             ok;
        logic [LEN_W-1:0] hdr_len;
        logic [LEN_W-1:0] pkt_len;
    } parse_result_t;

    typedef struct packed {
        logic             filled;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] hdr_len;
        logic [LEN_W-1:0] pkt_len;
    } slot_entry_t;

endpackage

// ===== design/rtp_reorder_buffer.sv =====
// ----------------------------------------------------------------------------
// rtp_reorder_buffer
// Reorders rtp packet descriptors by sequence number through a slot ring.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// while the request is worked through, and the final release of the request is
// shown in the first cycle with busy low again. Releases come out
// one per strobe cycle and cannot be held off; last marks the final one of a
// request. A rejected datagram returns to idle from the check state. Otherwise a
// small sequencer works through one slot memory with one read and one write
// port: each memory read is made in a read state and judged in the state after,
// and a request walks the slots while the head is forced forward, stores its
// packet and then releases packets in order. After reset the slot memory is
// cleared with busy high. RING_SLOTS must be a power of two.
// ----------------------------------------------------------------------------
module rtp_reorder_buffer #(
    parameter int RING_SLOTS = 64,
    parameter int SLOT_BYTES = 2048
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [rtprb_pkg::BYTE_W-1:0]       first_byte,
    input  logic [rtprb_pkg::SEQ_W-1:0]        seq_number,
    input  logic [rtprb_pkg::LEN_W-1:0]        dgram_len,
    input  logic [rtprb_pkg::EXTW_W-1:0]       ext_len,
    input  logic [rtprb_pkg::BYTE_W-1:0]       last_byte,
    input  logic                               cfg_we,
    input  logic [rtprb_pkg::DEPTH_W-1:0]      cfg_wdata,
    output logic                               strobe,
    output logic [rtprb_pkg::SLOT_PORT_W-1:0]  slot_index,
    output logic [rtprb_pkg::SEQ_W-1:0]        seq_out,
    output logic [rtprb_pkg::LEN_W-1:0]        header_len,
    output logic [rtprb_pkg::LEN_W-1:0]        packet_len,
    output logic [rtprb_pkg::LOST_W-1:0]       lost_total,
    output logic                               last
);

    localparam int IDX_W  = $clog2(RING_SLOTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int DIFF_W = rtprb_pkg::SEQ_W + 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_WREAD = 4'd3;
    localparam logic [3:0] S_WEVAL = 4'd4;
    localparam logic [3:0] S_SKIP  = 4'd5;
    localparam logic [3:0] S_IREAD = 4'd6;
    localparam logic [3:0] S_IEVAL = 4'd7;
    localparam logic [3:0] S_DREAD = 4'd8;
    localparam logic [3:0] S_DEVAL = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    // control state
    logic [3:0]                        state_reg, state_next;
    logic [IDX_W-1:0]                  clr_reg, clr_next;
    logic                              started_reg, started_next;
    logic [rtprb_pkg::SEQ_W-1:0]       exp_reg, exp_next;
    logic [CNT_W-1:0]                  pending_reg, pending_next;
    logic [rtprb_pkg::LOST_W-1:0]      lost_reg, lost_next;
    logic [rtprb_pkg::DEPTH_W-1:0]     depth_reg;
    logic [CNT_W-1:0]                  walk_reg, walk_next;
    logic [rtprb_pkg::SEQ_W-1:0]       skip_reg, skip_next;
    logic                              hold_valid_reg, hold_valid_next;
    logic                              strobe_reg, strobe_next;

    // request and result payload
    logic [rtprb_pkg::BYTE_W-1:0]      fb_reg;
    logic [rtprb_pkg::SEQ_W-1:0]       seq_reg;
    logic [rtprb_pkg::LEN_W-1:0]       len_reg;
    logic [rtprb_pkg::EXTW_W-1:0]      extw_reg;
    logic [rtprb_pkg::BYTE_W-1:0]      lastb_reg;
    logic [rtprb_pkg::SLOT_PORT_W-1:0] hold_slot_reg, hold_slot_next;
    rtprb_pkg::slot_entry_t            hold_ent_reg, hold_ent_next;
    logic [rtprb_pkg::LOST_W-1:0]      hold_lost_reg, hold_lost_next;
    logic [rtprb_pkg::SLOT_PORT_W-1:0] o_slot_reg, o_slot_next;
    rtprb_pkg::slot_entry_t            o_ent_reg, o_ent_next;
    logic [rtprb_pkg::LOST_W-1:0]      o_lost_reg, o_lost_next;
    logic                              o_last_reg, o_last_next;

    // slot memory
    rtprb_pkg::slot_entry_t            slot_mem [RING_SLOTS];
    rtprb_pkg::slot_entry_t            rd_reg;
    logic                              mem_we;
    logic [IDX_W-1:0]                  mem_waddr;
    rtprb_pkg::slot_entry_t            mem_wdata;
    logic [IDX_W-1:0]                  mem_raddr;

    rtprb_pkg::parse_result_t          parsed;

    logic                              accept;
    logic [rtprb_pkg::SEQ_W-1:0]       exp_eff;
    logic [rtprb_pkg::SEQ_W-1:0]       diff;
    logic [DIFF_W-1:0]                 depth_c;
    logic [DIFF_W-1:0]                 k_c;
    logic [DIFF_W-1:0]                 walk_c;
    logic                              hit;
    logic                              release_fire;
    logic [IDX_W-1:0]                  exp_idx;
    logic [IDX_W-1:0]                  seq_idx;

    rtprb_parse #(
        .SLOT_BYTES (SLOT_BYTES)
    ) u_parse (
        .first_byte (fb_reg),
        .dgram_len  (len_reg),
        .ext_len    (extw_reg),
        .last_byte  (lastb_reg),
        .result     (parsed)
    );

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign exp_idx = exp_reg[IDX_W-1:0];
    assign seq_idx = seq_reg[IDX_W-1:0];
    assign hit     = rd_reg.filled && (rd_reg.seq == exp_reg);

    // head position and forced advance length
    always_comb
    begin
        exp_eff = started_reg ? exp_reg : seq_reg;
        diff    = seq_reg - exp_eff;
        depth_c = DIFF_W'(depth_reg);
        if (depth_c == '0)
        begin
            depth_c = DIFF_W'(1);
        end
        else if (depth_c > DIFF_W'(RING_SLOTS))
        begin
            depth_c = DIFF_W'(RING_SLOTS);
        end
        k_c    = DIFF_W'(diff) - depth_c + DIFF_W'(1);
        walk_c = (k_c < DIFF_W'(RING_SLOTS)) ? k_c : DIFF_W'(RING_SLOTS);
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        started_next    = started_reg;
        exp_next        = exp_reg;
        pending_next    = pending_reg;
        lost_next       = lost_reg;
        walk_next       = walk_reg;
        skip_next       = skip_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        hold_ent_next   = hold_ent_reg;
        hold_lost_next  = hold_lost_reg;
        strobe_next     = 1'b0;
        o_slot_next     = o_slot_reg;
        o_ent_next      = o_ent_reg;
        o_lost_next     = o_lost_reg;
        o_last_next     = o_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = exp_idx;
        mem_wdata       = rd_reg;
        mem_wdata.filled = 1'b0;
        mem_raddr       = exp_idx;
        release_fire    = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == {IDX_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!parsed.ok)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    started_next = 1'b1;
                    exp_next     = exp_eff;
                    walk_next    = CNT_W'(walk_c);
                    skip_next    = rtprb_pkg::SEQ_W'(k_c - walk_c);
                    if (diff[rtprb_pkg::SEQ_W-1])
                    begin
                        state_next = S_IDLE;
                    end
                    else if (DIFF_W'(diff) >= depth_c)
                    begin
                        state_next = S_WREAD;
                    end
                    else
                    begin
                        state_next = S_IREAD;
                    end
                end
            end
            S_WREAD:
            begin
                state_next = S_WEVAL;
            end
            S_WEVAL:
            begin
                if (hit)
                begin
                    release_fire = 1'b1;
                    mem_we       = 1'b1;
                end
                else
                begin
                    lost_next = lost_reg + rtprb_pkg::LOST_W'(1);
                end
                exp_next  = exp_reg + rtprb_pkg::SEQ_W'(1);
                walk_next = walk_reg - CNT_W'(1);
                state_next = (walk_reg == CNT_W'(1)) ? S_SKIP : S_WREAD;
            end
            S_SKIP:
            begin
                lost_next  = lost_reg + rtprb_pkg::LOST_W'(skip_reg);
                exp_next   = exp_reg + skip_reg;
                state_next = S_IREAD;
            end
            S_IREAD:
            begin
                mem_raddr  = seq_idx;
                state_next = S_IEVAL;
            end
            S_IEVAL:
            begin
                if (rd_reg.filled)
                begin
                    if (rd_reg.seq != seq_reg)
                    begin
                        lost_next = lost_reg + rtprb_pkg::LOST_W'(1);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    mem_we            = 1'b1;
                    mem_waddr         = seq_idx;
                    mem_wdata.filled  = 1'b1;
                    mem_wdata.seq     = seq_reg;
                    mem_wdata.hdr_len = parsed.hdr_len;
                    mem_wdata.pkt_len = parsed.pkt_len;
                    pending_next      = pending_reg + CNT_W'(1);
                    state_next        = S_DREAD;
                end
            end
            S_DREAD:
            begin
                state_next = (pending_reg == '0) ? S_DONE : S_DEVAL;
            end
            S_DEVAL:
            begin
                if (hit)
                begin
                    release_fire = 1'b1;
                    mem_we       = 1'b1;
                    exp_next     = exp_reg + rtprb_pkg::SEQ_W'(1);
                    state_next   = S_DREAD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (hold_valid_reg)
                begin
                    strobe_next     = 1'b1;
                    o_slot_next     = hold_slot_reg;
                    o_ent_next      = hold_ent_reg;
                    o_lost_next     = hold_lost_reg;
                    o_last_next     = 1'b1;
                    hold_valid_next = 1'b0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // one result is held back so that the final one can carry last
        if (release_fire)
        begin
            if (pending_reg != '0)
            begin
                pending_next = pending_reg - CNT_W'(1);
            end
            if (hold_valid_reg)
            begin
                strobe_next = 1'b1;
                o_slot_next = hold_slot_reg;
                o_ent_next  = hold_ent_reg;
                o_lost_next = hold_lost_reg;
                o_last_next = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_slot_next  = rtprb_pkg::SLOT_PORT_W'(exp_idx);
            hold_ent_next   = rd_reg;
            hold_lost_next  = lost_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            started_reg    <= 1'b0;
            exp_reg        <= '0;
            pending_reg    <= '0;
            lost_reg       <= '0;
            depth_reg      <= rtprb_pkg::DEPTH_RESET;
            walk_reg       <= '0;
            skip_reg       <= '0;
            hold_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            started_reg    <= started_next;
            exp_reg        <= exp_next;
            pending_reg    <= pending_next;
            lost_reg       <= lost_next;
            walk_reg       <= walk_next;
            skip_reg       <= skip_next;
            hold_valid_reg <= hold_valid_next;
            strobe_reg     <= strobe_next;
            if (cfg_we)
            begin
                depth_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fb_reg    <= first_byte;
            seq_reg   <= seq_number;
            len_reg   <= dgram_len;
            extw_reg  <= ext_len;
            lastb_reg <= last_byte;
        end
        hold_slot_reg <= hold_slot_next;
        hold_ent_reg  <= hold_ent_next;
        hold_lost_reg <= hold_lost_next;
        o_slot_reg    <= o_slot_next;
        o_ent_reg     <= o_ent_next;
        o_lost_reg    <= o_lost_next;
        o_last_reg    <= o_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= slot_mem[mem_raddr];
    end

    assign strobe     = strobe_reg;
    assign slot_index = o_slot_reg;
    assign seq_out    = o_ent_reg.seq;
    assign header_len = o_ent_reg.hdr_len;
    assign packet_len = o_ent_reg.pkt_len;
    assign lost_total = o_lost_reg;
    assign last       = o_last_reg;

    // no held release may survive into idle
    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_valid_reg)
        else $error("held release left behind at idle");

    // a release without last always leaves another one held
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !o_last_reg) |-> hold_valid_reg)
        else $error("release without last but nothing held");

    // stored packet count never exceeds the ring
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(RING_SLOTS))
        else $error("pending count beyond ring size");

    // forced walk never runs on an empty count
    a_walk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WREAD) || (state_reg == S_WEVAL)) |-> (walk_reg != '0))
        else $error("walk with zero slots left");

    // a request is only taken once the clearing pass is over
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> ($past(state_reg) == S_IDLE))
        else $error("request taken outside idle");

endmodule

// ===== design/rtprb_parse.sv =====
// ----------------------------------------------------------------------------
// rtprb_parse
// Header checks, header length and padding removal for one rtp datagram.
// ----------------------------------------------------------------------------
module rtprb_parse #(
    parameter int SLOT_BYTES = 2048
) (
    input  logic [rtprb_pkg::BYTE_W-1:0] first_byte,
    input  logic [rtprb_pkg::LEN_W-1:0]  dgram_len,
    input  logic [rtprb_pkg::EXTW_W-1:0] ext_len,
    input  logic [rtprb_pkg::BYTE_W-1:0] last_byte,
    output rtprb_pkg::parse_result_t     result
);

    localparam int unsigned CALC_W = 19;

    logic              pad_bit;
    logic              ext_bit;
    logic [CALC_W-1:0] len_w;
    logic [CALC_W-1:0] hdr_base;
    logic [CALC_W-1:0] hdr_ext;
    logic [CALC_W-1:0] hdr;
    logic [CALC_W-1:0] room;
    logic [CALC_W-1:0] pad_w;
    logic [CALC_W-1:0] eff;
    logic              len_ok;
    logic              hdr_ok;
    logic              pad_ok;

    always_comb
    begin
        pad_bit  = first_byte[5];
        ext_bit  = first_byte[4];
        len_w    = CALC_W'(dgram_len);
        hdr_base = CALC_W'(rtprb_pkg::MIN_DGRAM_LEN) + CALC_W'({first_byte[3:0], 2'b00});
        hdr_ext  = hdr_base + CALC_W'(rtprb_pkg::EXT_HDR_BYTES) + CALC_W'({ext_len, 2'b00});
        hdr      = ext_bit ? hdr_ext : hdr_base;
        room     = len_w - hdr;
        pad_w    = pad_bit ? CALC_W'(last_byte) : '0;
        eff      = len_w - pad_w;

        len_ok   = (len_w >= CALC_W'(rtprb_pkg::MIN_DGRAM_LEN))
                && (len_w <= CALC_W'(SLOT_BYTES))
                && (first_byte[7:6] == rtprb_pkg::RTP_VERSION);
        hdr_ok   = (len_w >= hdr_base) && (!ext_bit || (len_w >= hdr_ext));
        pad_ok   = (pad_w <= room) && (eff <= CALC_W'(SLOT_BYTES));

        result.ok      = len_ok && hdr_ok && pad_ok;
        result.hdr_len = rtprb_pkg::LEN_W'(hdr);
        result.pkt_len = rtprb_pkg::LEN_W'(eff);
    end

endmodule
